// ===== rtl/pooled_cursor_list_manager_unit_defines.svh =====
// Assertion macros for the list manager checker.
`ifndef POOLED_CURSOR_LIST_MANAGER_UNIT_DEFINES_SVH
`define POOLED_CURSOR_LIST_MANAGER_UNIT_DEFINES_SVH
`define PCLM_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define PCLM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== rtl/pclm_pkg.sv =====
package pclm_pkg;
   localparam int POOL_NODES = 256;
   localparam int MAX_LISTS  = 16;
   localparam int NW = $clog2(POOL_NODES);
   localparam int LW = $clog2(MAX_LISTS);
   localparam int LINK_W = NW + 1;
   localparam int CNT_W = NW + 1;
   localparam int LU_W = LW + 1;
   localparam int LR_W = 3 * LINK_W + CNT_W;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_AFTER   = 3'd1;
   localparam logic [2:0] ACT_BEFORE  = 3'd2;
   localparam logic [2:0] ACT_APPEND  = 3'd3;
   localparam logic [2:0] ACT_PREPEND = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NULL    = 3'd1;
   localparam logic [2:0] ST_NO_NODE = 3'd2;
   localparam logic [2:0] ST_NO_LIST = 3'd3;
   localparam logic [2:0] ST_NO_HDL  = 3'd4;
   localparam logic [2:0] ST_BAD_CUR = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE, S_RDLIST, S_RDNODE, S_DECIDE, S_WRITE, S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_node;
      logic decide;
      logic write;
      logic respond;
   } ctrl_type;

   typedef struct packed {
      logic early_done;
   } stat_type;
endpackage

// ===== rtl/pclm_ram.sv =====
module pclm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/pclm_ctrl.sv =====
module pclm_ctrl import pclm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (start) state_in = S_RDLIST;
         S_RDLIST: state_in = S_RDNODE;
         S_RDNODE: state_in = stat.early_done ? S_DONE : S_DECIDE;
         S_DECIDE: state_in = S_WRITE;
         S_WRITE:  state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:   ctrl.load = start;
         S_RDLIST: ctrl.rd_node = 1'b1;
         S_DECIDE: ctrl.decide = 1'b1;
         S_WRITE:  ctrl.write = 1'b1;
         S_DONE:   ctrl.respond = 1'b1;
         default:  ctrl = '0;
      endcase
   end
endmodule

// ===== rtl/pclm_dp.sv =====
module pclm_dp import pclm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl,
   output stat_type         stat,
   input  logic [2:0]       req_action,
   input  logic [3:0]       req_list_handle,
   input  logic [31:0]      req_item_value,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_new_handle,
   output logic [7:0]       rsp_node_index,
   output logic [8:0]       rsp_list_length
);
   logic [2:0]        act_ff;
   logic [LW-1:0]     h_ff;
   logic [31:0]       item_ff;
   logic              hdl_bad_ff;
   logic [CNT_W-1:0]  nodes_used_ff;
   logic [LU_W-1:0]   lists_used_ff;
   logic [2:0]        st_ff, st_in;
   logic [LINK_W-1:0] nb_ff, nb_in;
   logic [LINK_W-1:0] pv_ff, pv_in, nx_ff, nx_in;
   logic [LINK_W-1:0] head_new_ff, head_new_in, tail_new_ff, tail_new_in;
   logic [NW-1:0]     nwa_ff, nwa_in, pwa_ff, pwa_in;
   logic              nwe_ff, nwe_in, pwe_ff, pwe_in;
   logic              bad_cur_in;
   logic              strobe_ff;
   logic [2:0]        status_ff;
   logic [LW-1:0]     handle_ff, handle_in;
   logic [NW-1:0]     index_ff, index_in;
   logic [CNT_W-1:0]  length_ff, length_in;
   logic              hdl_bad, is_add, ok_w, nb_ok;
   logic [NW-1:0]     new_n, nb_addr;

   // list record: head, tail, cursor, count
   logic              lr_we;
   logic [LW-1:0]     lr_waddr, lr_raddr;
   logic [LR_W-1:0]   lr_wdata, lr_rdata;
   logic [LINK_W-1:0] l_head, l_tail, l_cur;
   logic [CNT_W-1:0]  l_cnt;

   // node links, next and prev held apart so each write touches one link
   logic              nn_we, np_we;
   logic [NW-1:0]     nn_waddr, np_waddr;
   logic [LINK_W-1:0] nn_wdata, np_wdata, nb_next, nb_prev;
   logic              it_we;
   logic [31:0]       item_rd;

   assign hdl_bad = ({1'b0, req_list_handle} >= lists_used_ff);
   assign new_n = nodes_used_ff[NW-1:0];
   assign {l_head, l_tail, l_cur, l_cnt} = lr_rdata;
   assign is_add = act_ff inside {ACT_AFTER, ACT_BEFORE, ACT_APPEND, ACT_PREPEND};
   assign ok_w = (st_ff == ST_OK) && is_add;
   assign lr_raddr = ctrl.load ? req_list_handle[LW-1:0] : h_ff;
   assign stat.early_done = (st_ff != ST_OK) || !is_add;

   pclm_ram #(.WIDTH(LR_W), .DEPTH(MAX_LISTS)) u_lists (
      .clock, .wr_en(lr_we), .wr_addr(lr_waddr), .wr_data(lr_wdata),
      .rd_addr(lr_raddr), .rd_data(lr_rdata));

   pclm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next (
      .clock, .wr_en(nn_we), .wr_addr(nn_waddr), .wr_data(nn_wdata),
      .rd_addr(nb_addr), .rd_data(nb_next));

   pclm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_prev (
      .clock, .wr_en(np_we), .wr_addr(np_waddr), .wr_data(np_wdata),
      .rd_addr(nb_addr), .rd_data(nb_prev));

   pclm_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_items (
      .clock, .wr_en(it_we), .wr_addr(new_n), .wr_data(item_ff),
      .rd_addr(new_n), .rd_data(item_rd));

   // neighbor choice after list record read
   always_comb begin
      case (act_ff)
         ACT_APPEND:  nb_in = l_tail;
         ACT_PREPEND: nb_in = l_head;
         default:     nb_in = l_cur;
      endcase
   end
   assign nb_addr = nb_in[NW-1:0];
   assign nb_ok = (nb_ff < NIL);

   // early status at list read
   always_comb begin
      st_in = ST_OK;
      if (act_ff == ACT_CREATE) begin
         if (lists_used_ff >= LU_W'(MAX_LISTS)) st_in = ST_NO_LIST;
      end else if (is_add) begin
         if (hdl_bad_ff) st_in = ST_NO_HDL;
         else if (item_ff == '0) st_in = ST_NULL;
         else if (nodes_used_ff >= CNT_W'(POOL_NODES)) st_in = ST_NO_NODE;
      end
   end

   // decide links of the new node and the neighbor updates
   always_comb begin
      pv_in = NIL;
      nx_in = NIL;
      head_new_in = l_head;
      tail_new_in = l_tail;
      nwe_in = 1'b0;
      nwa_in = nb_ff[NW-1:0];
      pwe_in = 1'b0;
      pwa_in = nb_ff[NW-1:0];
      bad_cur_in = 1'b0;
      if (l_cnt == '0) begin
         head_new_in = {1'b0, new_n};
         tail_new_in = {1'b0, new_n};
      end else if (act_ff == ACT_AFTER || act_ff == ACT_APPEND) begin
         if (nb_ok && nb_ff == l_tail) begin
            pv_in = nb_ff;
            nwe_in = 1'b1;
            tail_new_in = {1'b0, new_n};
         end else if (nb_ok && nb_next < NIL) begin
            pv_in = nb_ff;
            nx_in = nb_next;
            nwe_in = 1'b1;
            pwe_in = 1'b1;
            pwa_in = nb_next[NW-1:0];
         end else begin
            bad_cur_in = 1'b1;
         end
      end else begin
         if (nb_ok && nb_ff == l_head) begin
            nx_in = nb_ff;
            pwe_in = 1'b1;
            head_new_in = {1'b0, new_n};
         end else if (nb_ok && nb_prev < NIL) begin
            nx_in = nb_ff;
            pv_in = nb_prev;
            pwe_in = 1'b1;
            nwe_in = 1'b1;
            nwa_in = nb_prev[NW-1:0];
         end else begin
            bad_cur_in = 1'b1;
         end
      end
   end

   always_comb begin
      handle_in = '0;
      index_in = '0;
      length_in = '0;
      if (act_ff == ACT_CREATE && st_ff == ST_OK) handle_in = lists_used_ff[LW-1:0];
      if (ok_w) begin
         index_in = new_n;
         length_in = l_cnt + CNT_W'(1);
      end else if (is_add && st_ff != ST_NO_HDL) begin
         length_in = l_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_used_ff <= '0;
         lists_used_ff <= '0;
         strobe_ff <= 1'b0;
         status_ff <= ST_OK;
         handle_ff <= '0;
         index_ff <= '0;
         length_ff <= '0;
      end else begin
         strobe_ff <= ctrl.respond;
         if (ctrl.respond && ok_w)
            nodes_used_ff <= nodes_used_ff + 1'b1;
         if (ctrl.respond && act_ff == ACT_CREATE && st_ff == ST_OK)
            lists_used_ff <= lists_used_ff + 1'b1;
         if (ctrl.respond) begin
            status_ff <= st_ff;
            handle_ff <= handle_in;
            index_ff <= index_in;
            length_ff <= length_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         act_ff <= req_action;
         h_ff <= req_list_handle[LW-1:0];
         item_ff <= req_item_value;
         hdl_bad_ff <= hdl_bad;
      end
      if (ctrl.rd_node) begin
         nb_ff <= nb_in;
         st_ff <= st_in;
      end
      if (ctrl.decide) begin
         pv_ff <= pv_in;
         nx_ff <= nx_in;
         head_new_ff <= head_new_in;
         tail_new_ff <= tail_new_in;
         nwe_ff <= nwe_in;
         nwa_ff <= nwa_in;
         pwe_ff <= pwe_in;
         pwa_ff <= pwa_in;
         if (bad_cur_in) st_ff <= ST_BAD_CUR;
      end
   end

   // neighbor links written in S_WRITE, new node links in S_DONE
   always_comb begin
      nn_we = 1'b0;
      nn_waddr = nwa_ff;
      nn_wdata = {1'b0, new_n};
      np_we = 1'b0;
      np_waddr = pwa_ff;
      np_wdata = {1'b0, new_n};
      if (ctrl.write && ok_w) begin
         nn_we = nwe_ff;
         np_we = pwe_ff;
      end else if (ctrl.respond && ok_w) begin
         nn_we = 1'b1;
         nn_waddr = new_n;
         nn_wdata = nx_ff;
         np_we = 1'b1;
         np_waddr = new_n;
         np_wdata = pv_ff;
      end
   end
   assign it_we = ctrl.respond && ok_w;

   always_comb begin
      lr_we = 1'b0;
      lr_waddr = h_ff;
      lr_wdata = '0;
      if (ctrl.respond && act_ff == ACT_CREATE && st_ff == ST_OK) begin
         lr_we = 1'b1;
         lr_waddr = lists_used_ff[LW-1:0];
         lr_wdata = {NIL, NIL, NIL, CNT_W'(0)};
      end else if (ctrl.respond && ok_w) begin
         lr_we = 1'b1;
         lr_wdata = {head_new_ff, tail_new_ff, {1'b0, new_n}, l_cnt + CNT_W'(1)};
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_new_handle = handle_ff;
   assign rsp_node_index = index_ff;
   assign rsp_list_length = length_ff;
endmodule

// ===== rtl/pooled_cursor_list_manager_unit.sv =====
// Pooled cursor list manager.
// Request channel: req_action, req_list_handle, req_item_value are taken at
// a rising edge with start high and busy low.
// Response channel: rsp_status, rsp_new_handle, rsp_node_index and
// rsp_list_length are valid for one cycle with rsp_strobe high.
// Sequence: create, unknown actions and requests rejected before the link read
// pass through S_RDLIST, S_RDNODE and S_DONE; add-type requests that reach
// the link read (placed or wrong cursor) also pass through S_DECIDE and
// S_WRITE. The strobe is registered from S_DONE.
// busy is high until the response cycle, so a new request can be taken at
// the edge that ends the response, and not before.
// A request that reaches the link read steps through the list record read,
// the neighbor link read, the link decision, the neighbor link write and
// the new node plus list record write, each RAM having one write port.
// Reset clears the node and list counters and the controller; list and node
// memories need no clearing since entries are only used after being written.
// The receiver cannot stall: each response shows for one cycle.
module pooled_cursor_list_manager_unit import pclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_list_handle,
   input  logic [31:0] req_item_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_new_handle,
   output logic [7:0]  rsp_node_index,
   output logic [8:0]  rsp_list_length
);
   ctrl_type ctrl;
   stat_type stat;

   pclm_ctrl u_ctrl (.clock, .reset, .start, .stat, .ctrl, .busy);
   pclm_dp u_dp (.clock, .reset, .ctrl, .stat, .req_action, .req_list_handle,
      .req_item_value, .rsp_strobe, .rsp_status, .rsp_new_handle,
      .rsp_node_index, .rsp_list_length);
endmodule

// ===== rtl/pclm_checker.sv =====
`include "pooled_cursor_list_manager_unit_defines.svh"
module pclm_checker import pclm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_node_index
);
   `PCLM_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `PCLM_ASSERT_NEXT(a_strobe_one, clock, reset, rsp_strobe, !rsp_strobe)
   `PCLM_ASSERT_IMPL(a_status_rng, clock, reset, rsp_strobe, rsp_status <= ST_BAD_CUR)
   `PCLM_ASSERT_IMPL(a_err_idx, clock, reset, rsp_strobe && rsp_status != ST_OK, rsp_node_index == 8'd0)
endmodule

bind pooled_cursor_list_manager_unit pclm_checker u_chk (.clock, .reset, .start,
   .busy, .rsp_strobe, .rsp_status, .rsp_node_index);
